// ===== sv/hpq_pkg.sv =====
// Shared types, constants and microcode labels of the heap priority queue.
package hpq_pkg;

  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KID_W = IDX_W + 2;
  localparam int UPC_W = 4;

  localparam logic [KEY_W-1:0] KEY_EMPTY = '1;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_RD_PARENT,
    ACT_UP_MOVE,
    ACT_INS_PLACE,
    ACT_RD_ENDS,
    ACT_EXT_LOAD,
    ACT_RD_KIDS,
    ACT_DN_MOVE,
    ACT_PLACE,
    ACT_EMIT
  } act_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_REJECT,
    COND_EXTRACT,
    COND_POS_ZERO,
    COND_UP_GT,
    COND_NO_LEFT,
    COND_DN_GO,
    COND_OUT_BUSY
  } cond_t;

  // One microcode word: datapath action, jump condition and jump target.
  typedef struct packed {
    act_t             act;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  // Datapath status seen by the jump logic.
  typedef struct packed {
    logic is_extract;
    logic reject;
    logic pos_zero;
    logic up_gt;
    logic no_left;
    logic dn_go;
    logic out_busy;
  } flags_t;

  localparam logic [UPC_W-1:0] S_WAIT     = 4'd0;
  localparam logic [UPC_W-1:0] S_DISPATCH = 4'd1;
  localparam logic [UPC_W-1:0] S_KIND     = 4'd2;
  localparam logic [UPC_W-1:0] S_UP_TEST  = 4'd3;
  localparam logic [UPC_W-1:0] S_UP_CMP   = 4'd4;
  localparam logic [UPC_W-1:0] S_UP_PLACE = 4'd5;
  localparam logic [UPC_W-1:0] S_EXT_READ = 4'd6;
  localparam logic [UPC_W-1:0] S_EXT_LOAD = 4'd7;
  localparam logic [UPC_W-1:0] S_DN_TEST  = 4'd8;
  localparam logic [UPC_W-1:0] S_DN_CMP   = 4'd9;
  localparam logic [UPC_W-1:0] S_DN_PLACE = 4'd10;
  localparam logic [UPC_W-1:0] S_TOP      = 4'd11;
  localparam logic [UPC_W-1:0] S_EMIT     = 4'd12;
  localparam logic [UPC_W-1:0] S_RESTART  = 4'd13;

endpackage

// ===== sv/hpq_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module hpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== sv/hpq_seq.sv =====
// Microcode sequencer: program ROM, step counter and conditional jumps.
module hpq_seq import hpq_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  flags_t flags,
  output ctrl_t  ctrl,
  output logic   in_stall
);

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             take;

  function automatic ctrl_t ucode(input logic [UPC_W-1:0] addr);
    ctrl_t w;
    begin
      unique case (addr)
        S_WAIT:     w = '{ACT_LOAD,      COND_NO_ITEM,  S_WAIT};
        S_DISPATCH: w = '{ACT_NONE,      COND_REJECT,   S_TOP};
        S_KIND:     w = '{ACT_NONE,      COND_EXTRACT,  S_EXT_READ};
        S_UP_TEST:  w = '{ACT_RD_PARENT, COND_POS_ZERO, S_UP_PLACE};
        S_UP_CMP:   w = '{ACT_UP_MOVE,   COND_UP_GT,    S_UP_TEST};
        S_UP_PLACE: w = '{ACT_INS_PLACE, COND_ALWAYS,   S_TOP};
        S_EXT_READ: w = '{ACT_RD_ENDS,   COND_NEVER,    S_WAIT};
        S_EXT_LOAD: w = '{ACT_EXT_LOAD,  COND_NEVER,    S_WAIT};
        S_DN_TEST:  w = '{ACT_RD_KIDS,   COND_NO_LEFT,  S_DN_PLACE};
        S_DN_CMP:   w = '{ACT_DN_MOVE,   COND_DN_GO,    S_DN_TEST};
        S_DN_PLACE: w = '{ACT_PLACE,     COND_NEVER,    S_WAIT};
        S_TOP:      w = '{ACT_NONE,      COND_NEVER,    S_WAIT};
        S_EMIT:     w = '{ACT_EMIT,      COND_OUT_BUSY, S_EMIT};
        S_RESTART:  w = '{ACT_NONE,      COND_ALWAYS,   S_WAIT};
        default:    w = '{ACT_NONE,      COND_ALWAYS,   S_WAIT};
      endcase
      return w;
    end
  endfunction

  assign ctrl     = ucode(upc_r);
  assign in_stall = (upc_r != S_WAIT);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_ITEM:  take = !in_valid;
      COND_REJECT:   take = flags.reject;
      COND_EXTRACT:  take = flags.is_extract;
      COND_POS_ZERO: take = flags.pos_zero;
      COND_UP_GT:    take = flags.up_gt;
      COND_NO_LEFT:  take = flags.no_left;
      COND_DN_GO:    take = flags.dn_go;
      COND_OUT_BUSY: take = flags.out_busy;
      default:       take = 1'b1;
    endcase
    upc_nxt = take ? ctrl.target : upc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == S_WAIT && in_valid) |=> (upc_r == S_DISPATCH))
    else $error("accepted item did not start its program");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == S_EMIT && flags.out_busy) |=> (upc_r == S_EMIT))
    else $error("sequencer left the emit step while the output was busy");

  a_idle_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r <= S_RESTART))
    else $error("step counter outside the program");
`endif

endmodule

// ===== sv/hpq_dp.sv =====
// Heap datapath: key store, sift registers, comparators and output register.
module hpq_dp import hpq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_t                   ctrl,
  output flags_t                  flags,
  input  logic                    in_valid,
  input  logic                    in_func,
  input  logic signed [KEY_W-1:0] in_key_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic signed [KEY_W-1:0] out_extracted_key,
  output logic signed [KEY_W-1:0] out_top_key,
  output logic [CNT_W-1:0]        out_entry_count
);

  status_t          status_r, status_nxt;
  logic             ext_r, ext_nxt;
  logic [KEY_W-1:0] taken_r, taken_nxt;
  logic [KEY_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [KEY_W-1:0] out_taken_r, out_taken_nxt;
  logic [KEY_W-1:0] out_top_r, out_top_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [KEY_W-1:0] ram_wdata, rdata_a, rdata_b;

  logic [IDX_W-1:0] parent;
  logic [KID_W-1:0] kid_l, kid_r, cnt_ext;
  logic             l_ok, r_ok, pick_l, pick_r, out_busy;
  logic [KEY_W-1:0] best_val;

  hpq_ram #(
    .WIDTH(KEY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr_a(ram_raddr_a),
    .rdata_a(rdata_a),
    .raddr_b(ram_raddr_b),
    .rdata_b(rdata_b)
  );

  assign parent  = (pos_r - 1'b1) >> 1;
  assign kid_l   = {1'b0, pos_r, 1'b1};
  assign kid_r   = kid_l + 1'b1;
  assign cnt_ext = KID_W'(cnt_r);
  assign l_ok    = kid_l < cnt_ext;
  assign r_ok    = kid_r < cnt_ext;

  // The left child wins ties, so the right one must be strictly greater.
  assign pick_l   = l_ok && ($signed(rdata_a) > $signed(cur_r));
  assign best_val = pick_l ? rdata_a : cur_r;
  assign pick_r   = r_ok && ($signed(rdata_b) > $signed(best_val));

  assign out_busy = out_valid_r && out_stall;

  assign flags.is_extract = ext_r;
  assign flags.reject     = (status_r != ST_DONE);
  assign flags.pos_zero   = (pos_r == '0);
  assign flags.up_gt      = $signed(cur_r) > $signed(rdata_a);
  assign flags.no_left    = !l_ok;
  assign flags.dn_go      = pick_l || pick_r;
  assign flags.out_busy   = out_busy;

  always_comb begin
    status_nxt     = status_r;
    ext_nxt        = ext_r;
    taken_nxt      = taken_r;
    cur_nxt        = cur_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    out_status_nxt = out_status_r;
    out_taken_nxt  = out_taken_r;
    out_top_nxt    = out_top_r;
    out_cnt_nxt    = out_cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = cur_r;
    ram_raddr_a    = '0;
    ram_raddr_b    = '0;

    unique case (ctrl.act)
      ACT_LOAD: begin
        if (in_valid) begin
          ext_nxt   = in_func;
          cur_nxt   = in_key_in;
          pos_nxt   = IDX_W'(cnt_r);
          taken_nxt = '0;
          status_nxt = ST_DONE;
          if (in_func == FUNC_INSERT) begin
            if (cnt_r == CNT_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end
          end else if (cnt_r == '0) begin
            status_nxt = ST_EMPTY;
            taken_nxt  = KEY_EMPTY;
          end
        end
      end
      ACT_RD_PARENT: begin
        ram_raddr_a = parent;
      end
      ACT_UP_MOVE: begin
        if (flags.up_gt) begin
          ram_we    = 1'b1;
          ram_wdata = rdata_a;
          pos_nxt   = parent;
        end
      end
      ACT_INS_PLACE: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
      ACT_RD_ENDS: begin
        ram_raddr_b = IDX_W'(cnt_r - 1'b1);
      end
      ACT_EXT_LOAD: begin
        taken_nxt = rdata_a;
        cur_nxt   = rdata_b;
        cnt_nxt   = cnt_r - 1'b1;
        pos_nxt   = '0;
      end
      ACT_RD_KIDS: begin
        ram_raddr_a = kid_l[IDX_W-1:0];
        ram_raddr_b = kid_r[IDX_W-1:0];
      end
      ACT_DN_MOVE: begin
        if (pick_l || pick_r) begin
          ram_we    = 1'b1;
          ram_wdata = pick_r ? rdata_b : rdata_a;
          pos_nxt   = pick_r ? kid_r[IDX_W-1:0] : kid_l[IDX_W-1:0];
        end
      end
      ACT_PLACE: begin
        ram_we = 1'b1;
      end
      ACT_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_taken_nxt  = taken_r;
          out_top_nxt    = (cnt_r != '0) ? rdata_a : '0;
          out_cnt_nxt    = cnt_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    ext_r        <= ext_nxt;
    taken_r      <= taken_nxt;
    cur_r        <= cur_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_taken_r  <= out_taken_nxt;
    out_top_r    <= out_top_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_extracted_key = out_taken_r;
  assign out_top_key       = out_top_r;
  assign out_entry_count   = out_cnt_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CNT_W'(DEPTH)))
    else $error("entry count beyond the heap depth");

  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_EMPTY) |->
      (out_taken_r == KEY_EMPTY && out_cnt_r == '0))
    else $error("empty extract beat carries a key or a count");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cnt_r == '0) |-> (out_top_r == '0))
    else $error("top key not zero on an empty heap");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + 1'b1 || cnt_r == $past(cnt_r) - 1'b1))
    else $error("entry count moved by more than one");
`endif

endmodule

// ===== sv/max_heap_priority_queue.sv =====
// Max-heap priority queue of signed keys, run by a microcoded sequencer.
// An insert sifts its key up and an extract sifts the last key down from the root, one level
// per pass of the sift loop; L, the number of levels the key moves, runs from 0 to log2 of the
// depth. A dropped insert or an empty extract skips the sift loop. The result beat appears
// before the next acceptance, and a stalled result holds the program at its emit step.
// Synchronous active-low reset empties the heap, restarts the program and drops any
// pending result; the key store itself is not cleared.
module max_heap_priority_queue import hpq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_func,
  input  logic signed [KEY_W-1:0] in_key_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic signed [KEY_W-1:0] out_extracted_key,
  output logic signed [KEY_W-1:0] out_top_key,
  output logic [CNT_W-1:0]        out_entry_count
);

  ctrl_t  ctrl;
  flags_t flags;

  hpq_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .flags   (flags),
    .ctrl    (ctrl),
    .in_stall(in_stall)
  );

  hpq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .flags            (flags),
    .in_valid         (in_valid),
    .in_func          (in_func),
    .in_key_in        (in_key_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_extracted_key(out_extracted_key),
    .out_top_key      (out_top_key),
    .out_entry_count  (out_entry_count)
  );

endmodule

// ===== tb/max_heap_priority_queue_checker.sv =====
// Checker for the heap priority queue: tracks accepted beats, predicts every result, compares.
`timescale 1ns / 100ps
module max_heap_priority_queue_checker import hpq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_func,
  input  logic signed [KEY_W-1:0] in_key_in,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [1:0]              out_status,
  input  logic signed [KEY_W-1:0] out_extracted_key,
  input  logic signed [KEY_W-1:0] out_top_key,
  input  logic [CNT_W-1:0]        out_entry_count,
  output int                      errors,
  output int                      pending
);

  typedef struct {
    status_t                 status;
    logic signed [KEY_W-1:0] taken;
    logic signed [KEY_W-1:0] top;
    logic [CNT_W-1:0]        count;
  } heap_reply_t;

  logic signed [KEY_W-1:0] heap_keys [DEPTH];
  int                      heap_size = 0;
  heap_reply_t             replies_due [$];

  initial begin
    errors = 0;
    pending = 0;
  end

  // Applies one operation to the local heap and returns the reply it should produce.
  function automatic heap_reply_t heap_apply(input logic func,
                                             input logic signed [KEY_W-1:0] key);
    heap_reply_t             rep;
    logic signed [KEY_W-1:0] held;
    int                      pos;
    int                      parent;
    int                      best;
    int                      kid;
    rep.status = ST_DONE;
    rep.taken = '0;
    if (func == FUNC_INSERT) begin
      if (heap_size >= DEPTH) begin
        rep.status = ST_FULL;
      end else begin
        pos = heap_size;
        heap_keys[pos] = key;
        heap_size++;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_keys[pos] <= heap_keys[parent]) break;
          held = heap_keys[pos];
          heap_keys[pos] = heap_keys[parent];
          heap_keys[parent] = held;
          pos = parent;
        end
      end
    end else if (heap_size == 0) begin
      rep.status = ST_EMPTY;
      rep.taken = KEY_EMPTY;
    end else begin
      rep.taken = heap_keys[0];
      heap_size--;
      heap_keys[0] = heap_keys[heap_size];
      pos = 0;
      forever begin
        // Strictly greater only, so the left child keeps a tie.
        best = pos;
        for (kid = 2 * pos + 1; kid <= 2 * pos + 2; kid++) begin
          if (kid < heap_size && heap_keys[kid] > heap_keys[best]) best = kid;
        end
        if (best == pos) break;
        held = heap_keys[pos];
        heap_keys[pos] = heap_keys[best];
        heap_keys[best] = held;
        pos = best;
      end
    end
    rep.top = (heap_size != 0) ? heap_keys[0] : '0;
    rep.count = CNT_W'(heap_size);
    return rep;
  endfunction

  always @(posedge clk) begin
    heap_reply_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) replies_due.push_back(heap_apply(in_func, in_key_in));
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result beat: status %0d extracted %0d top %0d count %0d",
                   $time, out_status, out_extracted_key, out_top_key, out_entry_count);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
            errors++;
          end
          if (out_extracted_key !== want.taken) begin
            $display("%0t: extracted_key mismatch: expected %0d, actual %0d",
                     $time, want.taken, out_extracted_key);
            errors++;
          end
          if (out_top_key !== want.top) begin
            $display("%0t: top_key mismatch: expected %0d, actual %0d",
                     $time, want.top, out_top_key);
            errors++;
          end
          if (out_entry_count !== want.count) begin
            $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                     $time, want.count, out_entry_count);
            errors++;
          end
        end
      end
      pending <= replies_due.size();
    end
  end

endmodule

// ===== tb/max_heap_priority_queue_tb.sv =====
// Testbench top for the heap priority queue: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 100ps
module max_heap_priority_queue_tb;
  import hpq_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 400;
  localparam int BURST_ITEMS  = 24;
  localparam int SETTLE       = 40;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_func = FUNC_INSERT;
  logic signed [KEY_W-1:0] in_key_in = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [1:0]              out_status;
  logic signed [KEY_W-1:0] out_extracted_key;
  logic signed [KEY_W-1:0] out_top_key;
  logic [CNT_W-1:0]        out_entry_count;

  int          errors;
  int          pending;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  bit          holding = 1'b0;
  int          holds_asked = 0;
  int          holds_done = 0;

  max_heap_priority_queue dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_key_in         (in_key_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_extracted_key (out_extracted_key),
    .out_top_key       (out_top_key),
    .out_entry_count   (out_entry_count)
  );

  max_heap_priority_queue_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_key_in         (in_key_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_extracted_key (out_extracted_key),
    .out_top_key       (out_top_key),
    .out_entry_count   (out_entry_count),
    .errors            (errors),
    .pending           (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Keys lean toward ties, small values and the signed extremes.
  function automatic logic signed [KEY_W-1:0] rand_key();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return $urandom;
    if (pick < 70) return int'($urandom_range(0, 8)) - 4;
    if (pick < 85) return int'($urandom_range(0, 2000)) - 1000;
    case ($urandom_range(0, 3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic int sender_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Holds one beat until it is taken; valid stays up when no gap follows.
  task automatic offer(input logic func, input logic signed [KEY_W-1:0] key, input int gap);
    in_valid <= 1'b1;
    in_func <= func;
    in_key_in <= key;
    do @(posedge clk); while (in_stall);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random stall runs, quiet stretches, and long holds on request.
  initial begin
    int unsigned pick;
    int          run;
    logic        stall_now;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        holding = 1'b0;
        holds_done++;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          stall_now = 1'b0;
          run = $urandom_range(1, 8);
        end else if (pick < 92) begin
          stall_now = 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          stall_now = 1'b1;
          run = $urandom_range(10, 40);
        end
        out_stall <= stall_now;
        repeat (run - 1) @(posedge clk);
      end
    end
  end

  initial begin
    int sent;
    int seg;
    int seg_len;
    int lean;
    int i;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty extract, signed extremes, ties, then drain past empty.
    offer(FUNC_EXTRACT, rand_key(), sender_gap());
    offer(FUNC_INSERT, '0, sender_gap());
    offer(FUNC_INSERT, 32'sh7fffffff, sender_gap());
    offer(FUNC_INSERT, 32'sh80000000, sender_gap());
    offer(FUNC_INSERT, '1, sender_gap());
    offer(FUNC_INSERT, 32'sd1, sender_gap());
    offer(FUNC_INSERT, 32'sd5, sender_gap());
    offer(FUNC_INSERT, 32'sd5, sender_gap());
    offer(FUNC_INSERT, 32'sh80000001, sender_gap());
    offer(FUNC_INSERT, 32'sh55555555, sender_gap());
    offer(FUNC_INSERT, 32'shaaaaaaaa, sender_gap());
    for (i = 0; i < 11; i++) offer(FUNC_EXTRACT, rand_key(), sender_gap());
    drain();

    // Random: alternating fill, drain and mixed stretches so the heap hits full and empty.
    sent = 0;
    seg = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      seg_len = $urandom_range(20, 45);
      case (seg % 3)
        0: lean = 85;
        1: lean = 15;
        default: lean = 50;
      endcase
      if (seg == 2 || seg == 9) begin
        // Receiver holds off while back-to-back inserts pile up behind the held result.
        drain();
        holds_asked++;
        while (!holding) @(posedge clk);
        for (i = 0; i < BURST_ITEMS; i++) offer(FUNC_INSERT, rand_key(), 0);
        sent += BURST_ITEMS;
        drain();
      end
      for (i = 0; i < seg_len; i++) begin
        offer(($urandom_range(0, 99) < lean) ? FUNC_INSERT : FUNC_EXTRACT, rand_key(),
              sender_gap());
      end
      sent += seg_len;
      if ($urandom_range(0, 3) == 0) drain();
      seg++;
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/hpq_pkg.sv
sv/hpq_ram.sv
sv/hpq_seq.sv
sv/hpq_dp.sv
sv/max_heap_priority_queue.sv
tb/max_heap_priority_queue_checker.sv
tb/max_heap_priority_queue_tb.sv
